// ===== sv/mlp_pkg.sv =====
package mlp_pkg;

  localparam int DATA_W          = 32;
  localparam int DEF_MAX_INPUTS  = 8;
  localparam int DEF_MAX_HIDDEN  = 16;
  localparam int DEF_MAX_OUTPUTS = 4;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int RESULT_LIMIT    = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd3;

  localparam logic [3:0]  RST_INPUT_COUNT   = 4'd2;
  localparam logic [4:0]  RST_HIDDEN_COUNT  = 5'd4;
  localparam logic [2:0]  RST_OUTPUT_COUNT  = 3'd1;
  localparam logic [16:0] RST_LEARNING_RATE = 17'd6554;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_INFER  = 2'd1;
  localparam logic [1:0] OP_TRAIN  = 2'd2;
  localparam logic [1:0] OP_TARGET = 2'd3;

  localparam logic LAYER_HIDDEN = 1'b0;
  localparam logic LAYER_OUTPUT = 1'b1;

  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_LOSS  = 1'b1;

  localparam logic [1:0] PH_ADDR = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_ACC  = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_FH    = 11'b000_0000_0010,
    S_FO    = 11'b000_0000_0100,
    S_EMIT  = 11'b000_0000_1000,
    S_LOSS  = 11'b000_0001_0000,
    S_HD    = 11'b000_0010_0000,
    S_STO   = 11'b000_0100_0000,
    S_UO    = 11'b000_1000_0000,
    S_STH   = 11'b001_0000_0000,
    S_UH    = 11'b010_0000_0000,
    S_REPLY = 11'b100_0000_0000
  } ctl_state_t;

  typedef struct packed {
    ctl_state_t state;
    logic [1:0] ph;
    logic       first;
    logic       lastj;
    logic       in_take;
    logic       out_load;
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] fx_sat(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = 64'shFFFF_FFFF_8000_0000;
    if (v > hi) return hi[DATA_W-1:0];
    else if (v < lo) return lo[DATA_W-1:0];
    else return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    return fx_sat(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    return fx_sat(64'(a) - 64'(b));
  endfunction

endpackage

// ===== sv/mlp_in_if.sv =====
interface mlp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic               layer;
  logic [3:0]         row;
  logic [3:0]         col;
  logic [2:0]         position;
  logic signed [31:0] value;
  logic               last;

  modport source(output valid, op, layer, row, col, position, value, last, input ready);
  modport sink(input valid, op, layer, row, col, position, value, last, output ready);
endinterface

// ===== sv/mlp_out_if.sv =====
interface mlp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         index;
  logic signed [31:0] value_res;
  logic               final_res;

  modport source(output valid, kind, index, value_res, final_res, input ready);
  modport sink(input valid, kind, index, value_res, final_res, output ready);
endinterface

// ===== sv/mlp_ram.sv =====
module mlp_ram #(
  parameter int W  = 32,
  parameter int D  = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/mlp_ctrl.sv =====
module mlp_ctrl #(
  parameter int MAX_INPUTS  = mlp_pkg::DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN  = mlp_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_OUTPUTS = mlp_pkg::DEF_MAX_OUTPUTS,
  localparam int MAXC = (MAX_INPUTS > MAX_HIDDEN)
                        ? ((MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS)
                        : ((MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS),
  localparam int CW = $clog2(MAXC + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic               in_last,
  output logic               in_ready,
  input  logic [3:0]         input_count,
  input  logic [4:0]         hidden_count,
  input  logic [2:0]         output_count,
  input  logic               out_free,
  output mlp_pkg::dp_cmd_t   cmd,
  output logic [CW-1:0]      idx_i,
  output logic [CW-1:0]      idx_j
);

  mlp_pkg::ctl_state_t state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic          train_r, train_nxt;
  logic [CW-1:0] ni, nh, no, nemit, ib, jb;
  logic          accept, compute, step_done, out_load, lastj, first;

  always_comb begin
    if (input_count == '0) ni = CW'(1);
    else if (32'(input_count) > MAX_INPUTS) ni = CW'(MAX_INPUTS);
    else ni = CW'(input_count);
    if (hidden_count == '0) nh = CW'(1);
    else if (32'(hidden_count) > MAX_HIDDEN) nh = CW'(MAX_HIDDEN);
    else nh = CW'(hidden_count);
    if (output_count == '0) no = CW'(1);
    else if (32'(output_count) > MAX_OUTPUTS) no = CW'(MAX_OUTPUTS);
    else no = CW'(output_count);
    nemit = (32'(no) > mlp_pkg::RESULT_LIMIT) ? CW'(mlp_pkg::RESULT_LIMIT) : no;
  end

  always_comb begin
    ib = CW'(1);
    jb = CW'(1);
    unique case (state_r)
      mlp_pkg::S_FH: begin
        ib = nh; jb = ni;
      end
      mlp_pkg::S_FO: begin
        ib = no; jb = nh;
      end
      mlp_pkg::S_EMIT: begin
        ib = nemit;
      end
      mlp_pkg::S_LOSS, mlp_pkg::S_STO: begin
        ib = no;
      end
      mlp_pkg::S_HD: begin
        ib = nh; jb = no;
      end
      mlp_pkg::S_UO: begin
        ib = no; jb = nh;
      end
      mlp_pkg::S_STH: begin
        ib = nh;
      end
      mlp_pkg::S_UH: begin
        ib = nh; jb = ni;
      end
      default: begin
        ib = CW'(1);
      end
    endcase
  end

  assign in_ready = (state_r == mlp_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign compute  = !(state_r == mlp_pkg::S_IDLE || state_r == mlp_pkg::S_EMIT ||
                      state_r == mlp_pkg::S_REPLY);
  assign out_load = (state_r == mlp_pkg::S_EMIT || state_r == mlp_pkg::S_REPLY) && out_free;
  assign step_done = (compute && ph_r == mlp_pkg::PH_ACC) || out_load;
  assign lastj = (state_r == mlp_pkg::S_EMIT) ? (i_r == ib - CW'(1)) : (j_r == jb - CW'(1));
  assign first = (state_r == mlp_pkg::S_LOSS) ? (i_r == '0) : (j_r == '0);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    ph_nxt    = ph_r;
    train_nxt = train_r;
    if (compute) begin
      ph_nxt = (ph_r == mlp_pkg::PH_ACC) ? mlp_pkg::PH_ADDR : ph_r + 2'd1;
    end
    if (state_r == mlp_pkg::S_IDLE) begin
      if (accept && in_last && (in_op == mlp_pkg::OP_INFER || in_op == mlp_pkg::OP_TARGET)) begin
        state_nxt = mlp_pkg::S_FH;
        train_nxt = (in_op == mlp_pkg::OP_TARGET);
        i_nxt     = '0;
        j_nxt     = '0;
        ph_nxt    = mlp_pkg::PH_ADDR;
      end
    end else if (state_r == mlp_pkg::S_REPLY) begin
      if (out_load) state_nxt = mlp_pkg::S_IDLE;
    end else if (step_done) begin
      if (j_r + CW'(1) < jb) begin
        j_nxt = j_r + CW'(1);
      end else begin
        j_nxt = '0;
        unique case (state_r)
          mlp_pkg::S_STO: state_nxt = mlp_pkg::S_UO;
          mlp_pkg::S_STH: state_nxt = mlp_pkg::S_UH;
          mlp_pkg::S_UO: begin
            if (i_r + CW'(1) < no) begin
              i_nxt = i_r + CW'(1); state_nxt = mlp_pkg::S_STO;
            end else begin
              i_nxt = '0; state_nxt = mlp_pkg::S_STH;
            end
          end
          mlp_pkg::S_UH: begin
            if (i_r + CW'(1) < nh) begin
              i_nxt = i_r + CW'(1); state_nxt = mlp_pkg::S_STH;
            end else begin
              i_nxt = '0; state_nxt = mlp_pkg::S_REPLY;
            end
          end
          default: begin
            if (i_r + CW'(1) < ib) begin
              i_nxt = i_r + CW'(1);
            end else begin
              i_nxt = '0;
              unique case (state_r)
                mlp_pkg::S_FH:   state_nxt = mlp_pkg::S_FO;
                mlp_pkg::S_FO:   state_nxt = train_r ? mlp_pkg::S_LOSS : mlp_pkg::S_EMIT;
                mlp_pkg::S_LOSS: state_nxt = mlp_pkg::S_HD;
                mlp_pkg::S_HD:   state_nxt = mlp_pkg::S_STO;
                default:         state_nxt = mlp_pkg::S_IDLE;
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlp_pkg::S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      ph_r    <= mlp_pkg::PH_ADDR;
      train_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      ph_r    <= ph_nxt;
      train_r <= train_nxt;
    end
  end

  always_comb begin
    cmd.state    = state_r;
    cmd.ph       = ph_r;
    cmd.first    = first;
    cmd.lastj    = lastj;
    cmd.in_take  = accept;
    cmd.out_load = out_load;
  end

  assign idx_i = i_r;
  assign idx_j = j_r;

endmodule

// ===== sv/mlp_datapath.sv =====
module mlp_datapath #(
  parameter int MAX_INPUTS  = mlp_pkg::DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN  = mlp_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_OUTPUTS = mlp_pkg::DEF_MAX_OUTPUTS,
  parameter int FRAC_BITS   = mlp_pkg::DEF_FRAC_BITS,
  localparam int MAXC = (MAX_INPUTS > MAX_HIDDEN)
                        ? ((MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS)
                        : ((MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS),
  localparam int CW = $clog2(MAXC + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mlp_pkg::dp_cmd_t cmd,
  input  logic [CW-1:0]    idx_i,
  input  logic [CW-1:0]    idx_j,
  input  logic [16:0]      learning_rate,
  mlp_in_if.sink           in_ch,
  mlp_out_if.source        out_ch,
  output logic             out_free
);

  localparam int DW  = mlp_pkg::DATA_W;
  localparam int HWD = MAX_HIDDEN * MAX_INPUTS;
  localparam int OWD = MAX_OUTPUTS * MAX_HIDDEN;
  localparam int HAW = (HWD > 1) ? $clog2(HWD) : 1;
  localparam int OAW = (OWD > 1) ? $clog2(OWD) : 1;
  localparam int IXW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int HXW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int OXW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  logic signed [DW-1:0] x_r   [MAX_INPUTS];
  logic signed [DW-1:0] t_r   [MAX_OUTPUTS];
  logic signed [DW-1:0] act_r [MAX_HIDDEN];
  logic signed [DW-1:0] ov_r  [MAX_OUTPUTS];
  logic signed [DW-1:0] od_r  [MAX_OUTPUTS];
  logic signed [DW-1:0] hd_r  [MAX_HIDDEN];

  logic signed [DW-1:0] acc_r, loss_r, step_r, err_r;
  logic signed [63:0]   p_r;
  logic signed [63:0]   q;
  logic signed [DW-1:0] sp, acc_new, err_nxt;
  logic signed [DW-1:0] mul_a, mul_b, rate_s;

  logic [IXW-1:0] jx, ix_pos;
  logic [HXW-1:0] jh, ih;
  logic [OXW-1:0] jo, io;

  logic           hw_we, ow_we, hw_re, ow_re;
  logic [HAW-1:0] hw_waddr, hw_raddr, hw_loop;
  logic [OAW-1:0] ow_waddr, ow_raddr, ow_loop;
  logic [DW-1:0]  hw_wdata, ow_wdata, hw_rdata, ow_rdata;
  logic           host_hw, host_ow, ph0, ph1, ph2;

  logic               out_valid_r, out_kind_r, out_final_r;
  logic [1:0]         out_index_r;
  logic signed [DW-1:0] out_value_r;

  assign jx = idx_j[IXW-1:0];
  assign jh = idx_j[HXW-1:0];
  assign jo = idx_j[OXW-1:0];
  assign ih = idx_i[HXW-1:0];
  assign io = idx_i[OXW-1:0];
  assign ix_pos = IXW'(in_ch.position);

  assign ph0 = (cmd.ph == mlp_pkg::PH_ADDR);
  assign ph1 = (cmd.ph == mlp_pkg::PH_MUL);
  assign ph2 = (cmd.ph == mlp_pkg::PH_ACC);

  assign rate_s = signed'({15'd0, learning_rate});

  // weight addressing for the sweeps
  always_comb begin
    hw_loop = HAW'(32'(idx_i) * MAX_INPUTS + 32'(idx_j));
    if (cmd.state == mlp_pkg::S_HD) ow_loop = OAW'(32'(idx_j) * MAX_HIDDEN + 32'(idx_i));
    else ow_loop = OAW'(32'(idx_i) * MAX_HIDDEN + 32'(idx_j));
  end

  assign host_hw = cmd.in_take && in_ch.op == mlp_pkg::OP_WEIGHT &&
                   in_ch.layer == mlp_pkg::LAYER_HIDDEN &&
                   32'(in_ch.row) < MAX_HIDDEN && 32'(in_ch.col) < MAX_INPUTS;
  assign host_ow = cmd.in_take && in_ch.op == mlp_pkg::OP_WEIGHT &&
                   in_ch.layer == mlp_pkg::LAYER_OUTPUT &&
                   32'(in_ch.row) < MAX_OUTPUTS && 32'(in_ch.col) < MAX_HIDDEN;

  assign q  = p_r >>> FRAC_BITS;
  assign sp = mlp_pkg::fx_sat(q);
  assign acc_new = mlp_pkg::fx_add(cmd.first ? '0 : acc_r, sp);
  assign err_nxt = mlp_pkg::fx_sub(t_r[io], ov_r[io]);

  always_comb begin
    hw_re    = ph0 && (cmd.state == mlp_pkg::S_FH || cmd.state == mlp_pkg::S_UH);
    ow_re    = ph0 && (cmd.state == mlp_pkg::S_FO || cmd.state == mlp_pkg::S_HD ||
                       cmd.state == mlp_pkg::S_UO);
    hw_raddr = hw_loop;
    ow_raddr = ow_loop;
    hw_we    = host_hw || (ph2 && cmd.state == mlp_pkg::S_UH);
    ow_we    = host_ow || (ph2 && cmd.state == mlp_pkg::S_UO);
    hw_waddr = host_hw ? HAW'(32'(in_ch.row) * MAX_INPUTS + 32'(in_ch.col)) : hw_loop;
    ow_waddr = host_ow ? OAW'(32'(in_ch.row) * MAX_HIDDEN + 32'(in_ch.col)) : ow_loop;
    hw_wdata = host_hw ? in_ch.value : mlp_pkg::fx_add(signed'(hw_rdata), sp);
    ow_wdata = host_ow ? in_ch.value : mlp_pkg::fx_add(signed'(ow_rdata), sp);
  end

  mlp_ram #(.W(DW), .D(HWD)) u_hw_ram (
    .clk(clk), .we(hw_we), .waddr(hw_waddr), .wdata(hw_wdata),
    .re(hw_re), .raddr(hw_raddr), .rdata(hw_rdata)
  );

  mlp_ram #(.W(DW), .D(OWD)) u_ow_ram (
    .clk(clk), .we(ow_we), .waddr(ow_waddr), .wdata(ow_wdata),
    .re(ow_re), .raddr(ow_raddr), .rdata(ow_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.state)
      mlp_pkg::S_FH: begin
        mul_a = signed'(hw_rdata); mul_b = x_r[jx];
      end
      mlp_pkg::S_FO: begin
        mul_a = signed'(ow_rdata); mul_b = act_r[jh];
      end
      mlp_pkg::S_LOSS: begin
        mul_a = err_r; mul_b = err_r;
      end
      mlp_pkg::S_HD: begin
        mul_a = od_r[jo]; mul_b = signed'(ow_rdata);
      end
      mlp_pkg::S_STO: begin
        mul_a = rate_s; mul_b = od_r[io];
      end
      mlp_pkg::S_UO: begin
        mul_a = step_r; mul_b = act_r[jh];
      end
      mlp_pkg::S_STH: begin
        mul_a = rate_s; mul_b = hd_r[ih];
      end
      mlp_pkg::S_UH: begin
        mul_a = step_r; mul_b = x_r[jx];
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ph1) begin
      p_r <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.in_take) begin
      if ((in_ch.op == mlp_pkg::OP_INFER || in_ch.op == mlp_pkg::OP_TRAIN) &&
          32'(in_ch.position) < MAX_INPUTS) begin
        x_r[ix_pos] <= in_ch.value;
      end
      if (in_ch.op == mlp_pkg::OP_TARGET && 32'(in_ch.position) < MAX_OUTPUTS) begin
        t_r[OXW'(in_ch.position)] <= in_ch.value;
      end
    end
    if (ph0 && cmd.state == mlp_pkg::S_LOSS) begin
      err_r    <= err_nxt;
      od_r[io] <= err_nxt;
    end
    if (ph2) begin
      case (cmd.state)
        mlp_pkg::S_FH: begin
          acc_r <= acc_new;
          if (cmd.lastj) act_r[ih] <= (acc_new > 0) ? acc_new : '0;
        end
        mlp_pkg::S_FO: begin
          acc_r <= acc_new;
          if (cmd.lastj) ov_r[io] <= acc_new;
        end
        mlp_pkg::S_HD: begin
          acc_r <= acc_new;
          if (cmd.lastj) hd_r[ih] <= (act_r[ih] > 0) ? acc_new : '0;
        end
        mlp_pkg::S_LOSS: begin
          loss_r <= mlp_pkg::fx_add(cmd.first ? '0 : loss_r, sp);
        end
        mlp_pkg::S_STO, mlp_pkg::S_STH: begin
          step_r <= sp;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.state == mlp_pkg::S_REPLY) begin
        out_kind_r  <= mlp_pkg::KIND_LOSS;
        out_index_r <= 2'd0;
        out_value_r <= loss_r;
        out_final_r <= 1'b1;
      end else begin
        out_kind_r  <= mlp_pkg::KIND_VALUE;
        out_index_r <= idx_i[1:0];
        out_value_r <= ov_r[io];
        out_final_r <= cmd.lastj;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.index     = out_index_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.final_res = out_final_r;

endmodule

// ===== sv/mlp_relu_forward_backprop.sv =====
// two-layer relu perceptron, q16.16, one shared 32x32 multiplier
// weight writes and non-final elements are taken while idle without starting a run
// inference: multiply-accumulate over the hidden then the output layer, then one item per output
// training: forward pass, loss, hidden deltas, output then hidden weight updates, then the loss item
// every step is address (weight read where needed), multiply, accumulate or store on the single multiplier
// reset clears control, output valid and config registers to defaults; weight and sample stores stay undefined
module mlp_relu_forward_backprop #(
  parameter int MAX_INPUTS  = mlp_pkg::DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN  = mlp_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_OUTPUTS = mlp_pkg::DEF_MAX_OUTPUTS,
  parameter int FRAC_BITS   = mlp_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mlp_in_if.sink                          in_ch,
  mlp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAXC = (MAX_INPUTS > MAX_HIDDEN)
                        ? ((MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS)
                        : ((MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS);
  localparam int CW = $clog2(MAXC + 1);

  logic [3:0]  input_count_r;
  logic [4:0]  hidden_count_r;
  logic [2:0]  output_count_r;
  logic [16:0] learning_rate_r;

  mlp_pkg::dp_cmd_t cmd;
  logic [CW-1:0]    idx_i, idx_j;
  logic             out_free, in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r   <= mlp_pkg::RST_INPUT_COUNT;
      hidden_count_r  <= mlp_pkg::RST_HIDDEN_COUNT;
      output_count_r  <= mlp_pkg::RST_OUTPUT_COUNT;
      learning_rate_r <= mlp_pkg::RST_LEARNING_RATE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlp_pkg::CFG_INPUT_COUNT:   input_count_r   <= cfg_data[3:0];
        mlp_pkg::CFG_HIDDEN_COUNT:  hidden_count_r  <= cfg_data[4:0];
        mlp_pkg::CFG_OUTPUT_COUNT:  output_count_r  <= cfg_data[2:0];
        mlp_pkg::CFG_LEARNING_RATE: learning_rate_r <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  mlp_ctrl #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN), .MAX_OUTPUTS(MAX_OUTPUTS)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_op(in_ch.op), .in_last(in_ch.last), .in_ready(in_ready),
    .input_count(input_count_r), .hidden_count(hidden_count_r),
    .output_count(output_count_r), .out_free(out_free),
    .cmd(cmd), .idx_i(idx_i), .idx_j(idx_j)
  );

  mlp_datapath #(
    .MAX_INPUTS(MAX_INPUTS), .MAX_HIDDEN(MAX_HIDDEN), .MAX_OUTPUTS(MAX_OUTPUTS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .idx_i(idx_i), .idx_j(idx_j),
    .learning_rate(learning_rate_r), .in_ch(in_ch), .out_ch(out_ch), .out_free(out_free)
  );

`ifndef SYNTH
  a_trigger_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready && in_ch.last &&
    (in_ch.op == mlp_pkg::OP_INFER || in_ch.op == mlp_pkg::OP_TARGET) |=> !in_ready)
    else $error("trigger item did not start a run");

  a_loss_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == mlp_pkg::KIND_LOSS |->
    out_ch.index == 2'd0 && out_ch.final_res)
    else $error("loss item malformed");

  a_plain_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready && in_ch.op == mlp_pkg::OP_WEIGHT |=> in_ready)
    else $error("weight write started a run");
`endif

endmodule
